[hdl/gpg_pkg.sv]
`timescale 1ns / 1ps

package gpg_pkg;

  // Leg count and index width
  localparam int LEGS  = 4;
  localparam int LEG_W = (LEGS > 1) ? $clog2(LEGS) : 1;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int PER_W   = 24;
  localparam int RATIO_W = 16;
  localparam int BIAS_W  = 17;
  localparam int PHASE_W = 16;
  localparam int MODE_W  = 2;
  localparam int FRAC_W  = 16;
  localparam int FULL_W  = PER_W + FRAC_W;
  localparam int MUL_W   = PER_W + BIAS_W;

  // Divider step counts
  localparam int MOD_STEPS = TIME_W;
  localparam int DIV_STEPS = PHASE_W;
  localparam int CNT_W     = $clog2(MOD_STEPS);

  // Fixed-point constants
  localparam logic [BIAS_W-1:0]  BIAS_ONE   = BIAS_W'(1) << FRAC_W;
  localparam logic [PHASE_W-1:0] PHASE_HALF = PHASE_W'(1) << (PHASE_W - 1);

  // Gait modes
  localparam logic [MODE_W-1:0] MODE_WAVE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SWING  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STANCE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd3;

  // Actions
  localparam logic ACT_COMPUTE = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // Configuration map
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W    = 32;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RATIO  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BIAS0  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BIAS1  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BIAS2  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BIAS3  = 3'd5;

  // Register reset values
  localparam logic [PER_W-1:0]   PERIOD_RST = 24'd500000;
  localparam logic [RATIO_W-1:0] RATIO_RST  = 16'd32768;
  localparam logic [BIAS_W-1:0]  BIAS0_RST  = 17'd0;
  localparam logic [BIAS_W-1:0]  BIAS1_RST  = 17'd32768;
  localparam logic [BIAS_W-1:0]  BIAS2_RST  = 17'd32768;
  localparam logic [BIAS_W-1:0]  BIAS3_RST  = 17'd0;

  typedef logic [PHASE_W-1:0] phase_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SP_MUL,
    ST_MOD,
    ST_LEG_MUL,
    ST_LEG_SUM,
    ST_LEG_CMP,
    ST_LEG_DIV,
    ST_APPLY
  } gpg_state_t;

endpackage

[hdl/gpg_if.sv]
`timescale 1ns / 1ps

// Input item channel
interface gpg_item_if;
  import gpg_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [MODE_W-1:0] gait_mode;
  logic [TIME_W-1:0] now_us;

  modport source (output valid, action, gait_mode, now_us, input ready);
  modport sink   (input valid, action, gait_mode, now_us, output ready);
endinterface

// Result item channel
interface gpg_result_if;
  import gpg_pkg::*;
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase_leg0;
  logic [PHASE_W-1:0] phase_leg1;
  logic [PHASE_W-1:0] phase_leg2;
  logic [PHASE_W-1:0] phase_leg3;
  logic [3:0]         contact_mask;

  modport source (output valid, phase_leg0, phase_leg1, phase_leg2, phase_leg3,
                  contact_mask, input ready);
  modport sink   (input valid, phase_leg0, phase_leg1, phase_leg2, phase_leg3,
                  contact_mask, output ready);
endinterface

[hdl/gait_phase_generator.sv]
`timescale 1ns / 1ps
// Channel   Kind          Payload
// item      valid/ready   action, gait_mode, now_us
// result    valid/ready   phase_leg0..3, contact_mask
// config    APB write/rd  period_us, stance_ratio, bias_leg0..3
//
// In a wave item, one shared restoring divider step unit runs 32 steps for
// elapsed mod period, then 16 quotient steps per leg, with one shared 24x17
// multiplier ahead of each leg. A compute item takes this path whenever the
// requested or the committed mode is wave; every other item (restart included)
// goes straight to the update state.
// Reset is synchronous; it restores the register defaults and the gait state.
// The block takes one item at a time; a result waiting on result.ready holds
// only the final update, and the next item is accepted meanwhile.

module gait_phase_generator (
  input  logic                       clk,
  input  logic                       rst,
  gpg_item_if.sink                   item,
  gpg_result_if.source               result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gpg_pkg::ADDR_W-1:0] paddr,
  input  logic [gpg_pkg::DATA_W-1:0] pwdata,
  output logic [gpg_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import gpg_pkg::*;

  // Configuration registers
  logic [PER_W-1:0]   period_us;
  logic [RATIO_W-1:0] stance_ratio;
  logic [BIAS_W-1:0]  bias_leg0, bias_leg1, bias_leg2, bias_leg3;

  // Gait state
  logic [TIME_W-1:0] start_time;
  logic [MODE_W-1:0] committed_mode;
  phase_t            old_phase  [LEGS];
  phase_t            last_phase [LEGS];
  logic [LEGS-1:0]   old_contact, pending_switch, last_contact;

  // Item latch and datapath
  gpg_state_t        state, state_next;
  logic              act_r;
  logic [MODE_W-1:0] mode_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] elapsed;
  logic [PER_W-1:0]  e_mod;
  logic [FULL_W-1:0] sp, prod, r_val, rem, den;
  logic              stance_r;
  logic [PHASE_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic [LEG_W-1:0]  leg;
  phase_t            wave_phase [LEGS];
  logic [LEGS-1:0]   wave_contact;
  logic              out_valid;

  // Control
  logic in_ready, accept, need_wave, out_free, apply_fire, mod_last, div_last;

  // Shared arithmetic
  logic [PER_W-1:0]    per;
  logic [FULL_W-1:0]   full;
  logic [BIAS_W-1:0]   bias_raw, bias_sat, mul_b;
  logic [MUL_W-1:0]    mul_out;
  logic                bit_in, ge;
  logic [FULL_W:0]     rem_sh, step_diff, sub_diff;
  logic [FULL_W-1:0]   rem_new, r_calc;

  // Update results
  logic [TIME_W-1:0] start_next;
  logic [MODE_W-1:0] committed_next;
  phase_t            old_phase_next  [LEGS];
  phase_t            last_phase_next [LEGS];
  logic [LEGS-1:0]   old_contact_next, pending_next, last_contact_next;

  // Output padding
  phase_t     phase_pad [4];
  logic [3:0] contact_pad;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      period_us    <= PERIOD_RST;
      stance_ratio <= RATIO_RST;
      bias_leg0    <= BIAS0_RST;
      bias_leg1    <= BIAS1_RST;
      bias_leg2    <= BIAS2_RST;
      bias_leg3    <= BIAS3_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[ADDR_W-1:2])
        REG_PERIOD: period_us    <= pwdata[PER_W-1:0];
        REG_RATIO:  stance_ratio <= pwdata[RATIO_W-1:0];
        REG_BIAS0:  bias_leg0    <= pwdata[BIAS_W-1:0];
        REG_BIAS1:  bias_leg1    <= pwdata[BIAS_W-1:0];
        REG_BIAS2:  bias_leg2    <= pwdata[BIAS_W-1:0];
        REG_BIAS3:  bias_leg3    <= pwdata[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_PERIOD: prdata = DATA_W'(period_us);
      REG_RATIO:  prdata = DATA_W'(stance_ratio);
      REG_BIAS0:  prdata = DATA_W'(bias_leg0);
      REG_BIAS1:  prdata = DATA_W'(bias_leg1);
      REG_BIAS2:  prdata = DATA_W'(bias_leg2);
      REG_BIAS3:  prdata = DATA_W'(bias_leg3);
      default:    prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign accept    = item.valid && in_ready;
  assign need_wave = (item.action == ACT_COMPUTE) &&
                     ((item.gait_mode == MODE_WAVE) ||
                      ((item.gait_mode != committed_mode) && (committed_mode == MODE_WAVE)));
  assign out_free  = !out_valid || result.ready;
  assign mod_last  = (cnt == CNT_W'(MOD_STEPS - 1));
  assign div_last  = (cnt == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = need_wave ? ST_SP_MUL : ST_APPLY;
      end
      ST_SP_MUL:  state_next = ST_MOD;
      ST_MOD: begin
        if (mod_last) state_next = ST_LEG_MUL;
      end
      ST_LEG_MUL: state_next = ST_LEG_SUM;
      ST_LEG_SUM: state_next = ST_LEG_CMP;
      ST_LEG_CMP: state_next = ST_LEG_DIV;
      ST_LEG_DIV: begin
        if (div_last) begin
          state_next = (leg == LEG_W'(LEGS - 1)) ? ST_APPLY : ST_LEG_MUL;
        end
      end
      ST_APPLY: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready   = 1'b0;
    bit_in     = 1'b0;
    apply_fire = 1'b0;
    unique case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_MOD:     bit_in = elapsed[TIME_W-1];
      ST_APPLY:   apply_fire = out_free;
      default: ;
    endcase
  end

  assign item.ready = in_ready;

  // ---------------- shared arithmetic ----------------
  assign per  = (period_us == '0) ? PER_W'(1) : period_us;
  assign full = {per, FRAC_W'(0)};

  // Pick the bias of the current leg and saturate it at one
  always_comb begin
    case (4'(leg))
      4'd0:    bias_raw = bias_leg0;
      4'd1:    bias_raw = bias_leg1;
      4'd2:    bias_raw = bias_leg2;
      4'd3:    bias_raw = bias_leg3;
      default: bias_raw = '0;
    endcase
    bias_sat = (bias_raw > BIAS_ONE) ? BIAS_ONE : bias_raw;
  end

  // One multiplier for the stance span and each leg's bias offset
  assign mul_b   = (state == ST_SP_MUL) ? BIAS_W'(stance_ratio) : bias_sat;
  assign mul_out = MUL_W'(per) * MUL_W'(mul_b);

  // One restoring divider step: shift in a bit, subtract when it fits
  assign rem_sh    = {rem, bit_in};
  assign step_diff = rem_sh - {1'b0, den};
  assign ge        = !step_diff[FULL_W];
  assign rem_new   = ge ? step_diff[FULL_W-1:0] : rem_sh[FULL_W-1:0];

  // Fold the bias offset back into one period
  assign sub_diff = {1'b0, e_mod, FRAC_W'(0)} - {1'b0, prod};
  assign r_calc   = sub_diff[FULL_W] ? (sub_diff[FULL_W-1:0] + full) : sub_diff[FULL_W-1:0];

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          act_r   <= item.action;
          mode_r  <= item.gait_mode;
          now_r   <= item.now_us;
          elapsed <= item.now_us - start_time;
        end
      end
      ST_SP_MUL: begin
        sp  <= mul_out[FULL_W-1:0];
        rem <= '0;
        den <= FULL_W'(per);
        cnt <= '0;
      end
      ST_MOD: begin
        rem     <= rem_new;
        elapsed <= elapsed << 1;
        cnt     <= cnt + 1'b1;
        if (mod_last) begin
          e_mod <= rem_new[PER_W-1:0];
          leg   <= '0;
        end
      end
      ST_LEG_MUL: prod  <= mul_out[FULL_W-1:0];
      ST_LEG_SUM: r_val <= r_calc;
      ST_LEG_CMP: begin
        stance_r <= (r_val < sp);
        rem      <= (r_val < sp) ? r_val : (r_val - sp);
        den      <= (r_val < sp) ? sp : (full - sp);
        cnt      <= '0;
      end
      ST_LEG_DIV: begin
        rem <= rem_new;
        quo <= {quo[PHASE_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (div_last) begin
          wave_phase[leg]   <= {quo[PHASE_W-2:0], ge};
          wave_contact[leg] <= stance_r;
          leg               <= leg + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------- gait state update ----------------
  always_comb begin
    last_phase_next   = last_phase;
    last_contact_next = last_contact;
    old_phase_next    = old_phase;
    old_contact_next  = old_contact;
    pending_next      = pending_switch;
    committed_next    = committed_mode;
    start_next        = start_time;
    if (act_r == ACT_RESTART) begin
      start_next       = now_r;
      old_contact_next = '0;
      for (int i = 0; i < LEGS; i++) old_phase_next[i] = PHASE_HALF;
      committed_next   = MODE_SWING;
      pending_next     = '0;
    end else begin
      // Drive the requested mode's output
      case (mode_r)
        MODE_WAVE: begin
          last_phase_next   = wave_phase;
          last_contact_next = wave_contact;
        end
        MODE_SWING: begin
          for (int i = 0; i < LEGS; i++) last_phase_next[i] = PHASE_HALF;
          last_contact_next = '0;
        end
        MODE_STANCE: begin
          for (int i = 0; i < LEGS; i++) last_phase_next[i] = PHASE_HALF;
          last_contact_next = '1;
        end
        default: ;
      endcase
      // Track the committed mode while a switch is requested
      if (mode_r != committed_mode) begin
        if (pending_switch == '0) pending_next = '1;
        case (committed_mode)
          MODE_WAVE: begin
            old_phase_next   = wave_phase;
            old_contact_next = wave_contact;
          end
          MODE_SWING: begin
            for (int i = 0; i < LEGS; i++) old_phase_next[i] = PHASE_HALF;
            old_contact_next = '0;
          end
          MODE_STANCE: begin
            for (int i = 0; i < LEGS; i++) old_phase_next[i] = PHASE_HALF;
            old_contact_next = '1;
          end
          default: ;
        endcase
        // Swing and stance swap all legs at once
        if (mode_r == MODE_STANCE && committed_mode == MODE_SWING) begin
          old_contact_next = '1;
        end else if (mode_r == MODE_SWING && committed_mode == MODE_STANCE) begin
          old_contact_next = '0;
        end
      end
      // Release agreeing legs, hold the others on the old output
      if (pending_next != '0) begin
        for (int i = 0; i < LEGS; i++) begin
          if (last_contact_next[i] == old_contact_next[i]) begin
            pending_next[i] = 1'b0;
          end else begin
            last_contact_next[i] = old_contact_next[i];
            last_phase_next[i]   = old_phase_next[i];
          end
        end
        if (pending_next == '0) committed_next = mode_r;
      end
    end
  end

  // Commit the update when the result slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time     <= '0;
      committed_mode <= MODE_SWING;
      old_contact    <= '0;
      pending_switch <= '0;
      last_contact   <= '0;
      for (int i = 0; i < LEGS; i++) begin
        old_phase[i]  <= PHASE_HALF;
        last_phase[i] <= PHASE_HALF;
      end
    end else if (apply_fire) begin
      start_time     <= start_next;
      committed_mode <= committed_next;
      old_contact    <= old_contact_next;
      pending_switch <= pending_next;
      last_contact   <= last_contact_next;
      old_phase      <= old_phase_next;
      last_phase     <= last_phase_next;
    end
  end

  // ---------------- result channel ----------------
  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (apply_fire)   out_valid <= 1'b1;
    else if (result.ready) out_valid <= 1'b0;
  end

  // Pad the leg outputs to four
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      phase_pad[i]   = (i < LEGS) ? last_phase[i % LEGS] : '0;
      contact_pad[i] = (i < LEGS) ? last_contact[i % LEGS] : 1'b0;
    end
  end

  assign result.valid        = out_valid;
  assign result.phase_leg0   = phase_pad[0];
  assign result.phase_leg1   = phase_pad[1];
  assign result.phase_leg2   = phase_pad[2];
  assign result.phase_leg3   = phase_pad[3];
  assign result.contact_mask = contact_pad;

  // ---------------- assertions ----------------
  // An accepted item moves the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("sequencer idle right after an accepted item");

  // A new result appears only out of the update state
  a_result_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_APPLY))
    else $error("result raised outside the update state");

  // The partial remainder stays below the divisor on every step
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD || state == ST_LEG_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

endmodule

[verif/gait_phase_generator_tb.sv]
`timescale 1ns / 1ps

module gait_phase_generator_tb;
  import gpg_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 150;

  typedef logic [LEGS-1:0][PHASE_W-1:0] leg_phases_t;

  typedef struct packed {
    leg_phases_t     phase;
    logic [LEGS-1:0] contact;
  } gait_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  gpg_item_if   item_bus ();
  gpg_result_if result_bus ();

  gait_phase_generator dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Gait model registers and state
  logic [PER_W-1:0]   cfg_period;
  logic [RATIO_W-1:0] cfg_ratio;
  logic [BIAS_W-1:0]  cfg_bias [LEGS];
  logic [TIME_W-1:0]  gait_start;
  logic [MODE_W-1:0]  gait_committed;
  leg_phases_t        held_phase;
  leg_phases_t        out_phase;
  logic [LEGS-1:0]    held_contact;
  logic [LEGS-1:0]    legs_pending;
  logic [LEGS-1:0]    out_contact;

  gait_result_t gait_expected [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit steady_flow = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result channel about 29 percent of the time, unless steady_flow is set
  always @(posedge clk) begin
    result_bus.ready <= steady_flow || ($urandom_range(99) >= 29);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gait_phase_generator verification failed");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s at %0t: expected %0d, got %0d", what, $time, want, got);
  endtask

  function automatic void reset_model();
    cfg_period     = PERIOD_RST;
    cfg_ratio      = RATIO_RST;
    cfg_bias[0]    = BIAS0_RST;
    cfg_bias[1]    = BIAS1_RST;
    cfg_bias[2]    = BIAS2_RST;
    cfg_bias[3]    = BIAS3_RST;
    gait_start     = '0;
    gait_committed = MODE_SWING;
    held_contact   = '0;
    legs_pending   = '0;
    out_contact    = '0;
    for (int i = 0; i < LEGS; i++) begin
      held_phase[i] = PHASE_HALF;
      out_phase[i]  = PHASE_HALF;
    end
  endfunction

  // Phase and contact of every leg in one mode; hold mode leaves both untouched
  function automatic void gait_wave(input logic [MODE_W-1:0] mode,
                                    input logic [TIME_W-1:0] now,
                                    inout leg_phases_t ph, inout logic [LEGS-1:0] ct);
    logic [63:0] per;
    logic [63:0] full;
    logic [63:0] sp;
    logic [63:0] b;
    logic [63:0] t;
    logic [63:0] r;
    logic [TIME_W-1:0] elapsed;
    if (mode == MODE_WAVE) begin
      per = (cfg_period == '0) ? 64'd1 : 64'(cfg_period);
      full = per << FRAC_W;
      sp = per * 64'(cfg_ratio);
      elapsed = now - gait_start;
      ct = '0;
      for (int i = 0; i < LEGS; i++) begin
        // saturate the offset at one full cycle
        b = (cfg_bias[i] > BIAS_ONE) ? 64'(BIAS_ONE) : 64'(cfg_bias[i]);
        t = (64'(elapsed) << FRAC_W) + full - per * b;
        r = t % full;
        if (r < sp) begin
          ct[i] = 1'b1;
          ph[i] = PHASE_W'((r << FRAC_W) / sp);
        end else begin
          ph[i] = PHASE_W'(((r - sp) << FRAC_W) / (full - sp));
        end
      end
    end else if (mode == MODE_SWING || mode == MODE_STANCE) begin
      for (int i = 0; i < LEGS; i++) ph[i] = PHASE_HALF;
      ct = (mode == MODE_STANCE) ? '1 : '0;
    end
  endfunction

  // Advance the gait state by one item and queue the result it yields
  function automatic void advance_gait(input logic act, input logic [MODE_W-1:0] mode,
                                       input logic [TIME_W-1:0] now);
    if (act == ACT_RESTART) begin
      gait_start = now;
      held_contact = '0;
      for (int i = 0; i < LEGS; i++) held_phase[i] = PHASE_HALF;
      gait_committed = MODE_SWING;
      legs_pending = '0;
    end else begin
      gait_wave(mode, now, out_phase, out_contact);
      if (mode != gait_committed) begin
        if (legs_pending == '0) legs_pending = '1;
        gait_wave(gait_committed, now, held_phase, held_contact);
        // swing and stance swap contacts on every leg at once
        if (mode == MODE_STANCE && gait_committed == MODE_SWING) held_contact = '1;
        else if (mode == MODE_SWING && gait_committed == MODE_STANCE) held_contact = '0;
      end
      if (legs_pending != '0) begin
        for (int i = 0; i < LEGS; i++) begin
          if (out_contact[i] == held_contact[i]) begin
            legs_pending[i] = 1'b0;
          end else begin
            out_contact[i] = held_contact[i];
            out_phase[i] = held_phase[i];
          end
        end
        if (legs_pending == '0) gait_committed = mode;
      end
    end
    gait_expected.push_back('{phase: out_phase, contact: out_contact});
  endfunction

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    gait_result_t want;
    leg_phases_t got_phase;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got_phase = {result_bus.phase_leg3, result_bus.phase_leg2,
                   result_bus.phase_leg1, result_bus.phase_leg0};
      if (gait_expected.size() == 0) begin
        note_mismatch("result with nothing expected", 0, 0);
      end else begin
        want = gait_expected.pop_front();
        for (int i = 0; i < LEGS; i++)
          if (got_phase[i] !== want.phase[i])
            note_mismatch($sformatf("phase_leg%0d", i), want.phase[i], got_phase[i]);
        if (result_bus.contact_mask !== want.contact)
          note_mismatch("contact_mask", want.contact, result_bus.contact_mask);
      end
    end
  end

  // Send one item; valid stays high afterwards so a following item goes back to back
  task automatic send_item(input logic act, input logic [MODE_W-1:0] mode,
                           input logic [TIME_W-1:0] now);
    int gap;
    if (!steady_flow && $urandom_range(99) < 29) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(150, 5) : $urandom_range(4, 1);
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid     <= 1'b1;
    item_bus.action    <= act;
    item_bus.gait_mode <= mode;
    item_bus.now_us    <= now;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    advance_gait(act, mode, now);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    while (gait_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_PERIOD: cfg_period  = value[PER_W-1:0];
      REG_RATIO:  cfg_ratio   = value[RATIO_W-1:0];
      REG_BIAS0:  cfg_bias[0] = value[BIAS_W-1:0];
      REG_BIAS1:  cfg_bias[1] = value[BIAS_W-1:0];
      REG_BIAS2:  cfg_bias[2] = value[BIAS_W-1:0];
      REG_BIAS3:  cfg_bias[3] = value[BIAS_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_gait_config(input logic [PER_W-1:0] per, input logic [RATIO_W-1:0] ratio,
                                 input logic [BIAS_W-1:0] b0, input logic [BIAS_W-1:0] b1,
                                 input logic [BIAS_W-1:0] b2, input logic [BIAS_W-1:0] b3);
    write_reg(REG_PERIOD, DATA_W'(per));
    write_reg(REG_RATIO, DATA_W'(ratio));
    write_reg(REG_BIAS0, DATA_W'(b0));
    write_reg(REG_BIAS1, DATA_W'(b1));
    write_reg(REG_BIAS2, DATA_W'(b2));
    write_reg(REG_BIAS3, DATA_W'(b3));
  endtask

  function automatic logic [PER_W-1:0] random_period();
    case ($urandom_range(2))
      0: return PER_W'($urandom_range(64, 1));
      1: return PER_W'($urandom_range(2_000_000, 1000));
      default: return PER_W'($urandom);
    endcase
  endfunction

  // Mostly within one gait period, sometimes exactly at an end, sometimes past one
  function automatic logic [BIAS_W-1:0] random_bias();
    case ($urandom_range(7))
      0: return BIAS_W'($urandom_range(131071, 65537));
      1: return ($urandom_range(1) == 0) ? '0 : BIAS_ONE;
      default: return BIAS_W'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return MODE_WAVE;
    if (roll < 70) return MODE_SWING;
    if (roll < 90) return MODE_STANCE;
    return MODE_HOLD;
  endfunction

  // Restart, then a run of compute items with rising time and occasional mode
  // changes; a share of fully random items breaks the runs up
  task automatic run_gait_sequences(input int count);
    int sent;
    int run_len;
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] now;
    logic [31:0] step_max;
    sent = 0;
    now = $urandom;
    step_max = ((cfg_period == '0) ? 32'd1 : 32'(cfg_period)) / 5 + 1;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        send_item(1'($urandom_range(1)), MODE_W'($urandom_range(3)), $urandom);
        sent++;
      end else begin
        now = now + $urandom_range(step_max * 4, 0);
        send_item(ACT_RESTART, MODE_W'($urandom_range(3)), now);
        sent++;
        mode = pick_mode();
        run_len = $urandom_range(30, 4);
        repeat (run_len) begin
          if ($urandom_range(5) == 0) mode = pick_mode();
          now = now + $urandom_range(step_max, 0);
          send_item(ACT_COMPUTE, mode, now);
          sent++;
        end
      end
    end
  endtask

  // Mode changes and time extremes under the reset configuration
  task automatic test_mode_transitions();
    send_item(ACT_COMPUTE, MODE_SWING, 32'd0);
    send_item(ACT_COMPUTE, MODE_STANCE, 32'd10);
    send_item(ACT_COMPUTE, MODE_STANCE, 32'd20);
    send_item(ACT_COMPUTE, MODE_SWING, 32'd30);
    send_item(ACT_COMPUTE, MODE_WAVE, 32'd0);
    send_item(ACT_COMPUTE, MODE_WAVE, 32'd125000);
    send_item(ACT_COMPUTE, MODE_WAVE, 32'd250000);
    send_item(ACT_COMPUTE, MODE_WAVE, 32'd375000);
    send_item(ACT_COMPUTE, MODE_WAVE, 32'd499999);
    send_item(ACT_COMPUTE, MODE_HOLD, 32'd600000);
    send_item(ACT_COMPUTE, MODE_HOLD, 32'd700000);
    send_item(ACT_RESTART, MODE_WAVE, 32'hFFFF_FFFF);
    send_item(ACT_COMPUTE, MODE_WAVE, 32'd0);
    send_item(ACT_COMPUTE, MODE_WAVE, 32'hFFFF_FFFE);
    send_item(ACT_COMPUTE, MODE_STANCE, 32'h7FFF_FFFF);
    drain_results();
  endtask

  // Zero period, zero ratio, saturated offsets, then the largest settings
  task automatic test_config_extremes();
    set_gait_config('0, '0, BIAS_ONE, 17'h1FFFF, 17'd65535, 17'd1);
    send_item(ACT_RESTART, MODE_HOLD, 32'd0);
    send_item(ACT_COMPUTE, MODE_WAVE, 32'd0);
    send_item(ACT_COMPUTE, MODE_WAVE, 32'd1);
    send_item(ACT_COMPUTE, MODE_WAVE, 32'd3);
    drain_results();
    set_gait_config(24'hFFFFFF, 16'hFFFF, '0, BIAS_ONE, 17'd1, 17'h10001);
    send_item(ACT_RESTART, MODE_WAVE, 32'd0);
    send_item(ACT_COMPUTE, MODE_WAVE, 32'd16777214);
    send_item(ACT_COMPUTE, MODE_WAVE, 32'hFFFF_FFFF);
    send_item(ACT_COMPUTE, MODE_SWING, 32'd5);
    drain_results();
  endtask

  // Random gait runs over several settings; one phase runs without stalls
  task automatic test_random_gaits();
    for (int ph = 0; ph < 6; ph++) begin
      steady_flow = (ph == 2);
      case (ph)
        0: set_gait_config(24'd1, 16'd1, '0, BIAS_ONE, random_bias(), random_bias());
        1: set_gait_config(24'hFFFFFF, 16'hFFFF, random_bias(), random_bias(),
                           17'h1FFFF, random_bias());
        3: set_gait_config('0, '0, random_bias(), random_bias(), random_bias(),
                           random_bias());
        default: set_gait_config(random_period(), RATIO_W'($urandom), random_bias(),
                                 random_bias(), random_bias(), random_bias());
      endcase
      run_gait_sequences(220);
      drain_results();
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    reset_model();
    rst                 <= 1'b1;
    item_bus.valid      <= 1'b0;
    item_bus.action     <= ACT_COMPUTE;
    item_bus.gait_mode  <= MODE_WAVE;
    item_bus.now_us     <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_mode_transitions();
    test_config_extremes();
    test_random_gaits();

    // hold a while so a stray result still shows up
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("gait_phase_generator verification clean");
    end else begin
      $display("gait_phase_generator verification failed");
    end
    $finish;
  end

endmodule
